// File: rtl/fixed_timestep_accumulator_defines.svh
// Assertion macros for the fixed-timestep accumulator.
// Used by rtl/fixed_timestep_accumulator.sv; expects clk and rst_n in scope.
`ifndef FIXED_TIMESTEP_ACCUMULATOR_DEFINES_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fta_pkg.sv
// Package for the fixed-timestep accumulator: field widths, register
// indexes and register reset values. No dependencies.
package fta_pkg;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 6;
    localparam int TOTAL_W = 64;
    localparam int INDEX_W = 2;

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [INDEX_W-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t REG_STEP_PERIOD  = 2'd0;
    localparam cfg_index_t REG_SUBSTEP_MAX  = 2'd1;
    localparam cfg_index_t REG_ACCUM_CAP    = 2'd2;
    localparam cfg_index_t REG_DROP_EXCESS  = 2'd3;

    // Register values after reset.
    localparam time_t  RST_STEP_PERIOD  = 32'd16667;
    localparam count_t RST_SUBSTEP_MAX  = 6'd8;
    localparam time_t  RST_ACCUM_CAP    = 32'd250000;
    localparam logic   RST_DROP_EXCESS  = 1'b1;

endpackage

// File: rtl/fixed_timestep_accumulator.sv
// Fixed-timestep accumulator top level: sequencer around one shared subtractor.
// Depends on rtl/fta_pkg.sv and rtl/fixed_timestep_accumulator_defines.svh.

// One elapsed-time item is taken per frame (in_stall is low only while the
// block is idle). It produces one step-pulse item per fired substep and then
// a summary item with last set. A shared 33-bit subtractor does every time
// compare and subtract: cap selection, clamping, one substep per cycle while
// the output is not stalled, and a restoring modulo when the substep limit is
// hit and excess time is dropped. With step_period or the substep maximum at
// zero only the summary item is sent.

`include "fixed_timestep_accumulator_defines.svh"

module fixed_timestep_accumulator
    import fta_pkg::*;
#(
    parameter int SUBSTEP_CAP = 63
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port
    input  logic                      cfg_we,
    input  cfg_index_t                cfg_index,
    input  time_t                     cfg_data,
    // Input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [TIME_W-1:0]  elapsed_time,
    // Output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      fire_step,
    output count_t                    step_number,
    output logic                      last,
    output count_t                    steps_this_update,
    output time_t                     carried_time,
    output total_t                    completed_total
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_CLAMP = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;

    localparam count_t CAP_LIMIT = COUNT_W'(SUBSTEP_CAP);

    // Configuration registers.
    time_t  step_period_reg;
    count_t substep_max_reg;
    time_t  accum_cap_reg;
    logic   drop_excess_reg;

    // Block state and working registers.
    logic [2:0]        state_reg, state_next;
    time_t             acc_reg, acc_next;
    total_t            total_reg, total_next;
    time_t             dt_reg, dt_next;
    time_t             cap_reg, cap_next;
    logic [TIME_W:0]   sum_reg, sum_next;
    count_t            n_reg, n_next;
    time_t             rem_reg, rem_next;
    logic [4:0]        bit_cnt_reg, bit_cnt_next;

    // Output register.
    logic   out_valid_reg, out_valid_next;
    logic   fire_reg, fire_next;
    count_t num_reg, num_next;
    logic   last_reg, last_next;
    count_t count_reg, count_next;
    time_t  carried_reg, carried_next;
    total_t out_total_reg, out_total_next;

    // Shared subtractor.
    logic [TIME_W:0]   sub_a, sub_b;
    logic [TIME_W+1:0] sub_diff;
    logic              sub_borrow;

    count_t            limit;
    logic              disabled;
    logic              out_free;
    logic [TIME_W:0]   mod_shift;
    total_t            total_sum;

    // The substep limit is the smaller of the register and the cap.
    assign limit    = (substep_max_reg < CAP_LIMIT) ? substep_max_reg : CAP_LIMIT;
    assign disabled = (step_period_reg == '0) || (limit == '0);
    assign out_free = !out_valid_reg || !out_stall;
    assign mod_shift = {rem_reg, acc_reg[TIME_W-1]};
    assign total_sum = total_reg + TOTAL_W'(n_reg);

    // Operand selection for the shared subtractor.
    always_comb
    begin
        sub_a = {1'b0, acc_reg};
        sub_b = {1'b0, step_period_reg};
        unique case (state_reg)
            S_LOAD:
            begin
                sub_a = {1'b0, accum_cap_reg};
            end
            S_CLAMP:
            begin
                sub_a = sum_reg;
                sub_b = {1'b0, cap_reg};
            end
            S_MOD:
            begin
                sub_a = mod_shift;
            end
            S_IDLE, S_STEP, S_SUM:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[TIME_W+1];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg  <= RST_STEP_PERIOD;
            substep_max_reg  <= RST_SUBSTEP_MAX;
            accum_cap_reg    <= RST_ACCUM_CAP;
            drop_excess_reg  <= RST_DROP_EXCESS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_PERIOD:  step_period_reg  <= cfg_data;
                REG_SUBSTEP_MAX:  substep_max_reg  <= cfg_data[COUNT_W-1:0];
                REG_ACCUM_CAP:    accum_cap_reg    <= cfg_data;
                REG_DROP_EXCESS:  drop_excess_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        dt_next        = dt_reg;
        cap_next       = cap_reg;
        sum_next       = sum_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        fire_next      = fire_reg;
        num_next       = num_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        carried_next   = carried_reg;
        out_total_next = out_total_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // Negative elapsed time counts as zero.
                    dt_next    = elapsed_time[TIME_W-1] ? '0 : time_t'(elapsed_time);
                    n_next     = '0;
                    state_next = disabled ? S_SUM : S_LOAD;
                end
            end
            S_LOAD:
            begin
                // Cap is raised to at least one period; the sum cannot overflow.
                cap_next   = sub_borrow ? step_period_reg : accum_cap_reg;
                sum_next   = {1'b0, acc_reg} + {1'b0, dt_reg};
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                acc_next   = sub_borrow ? sum_reg[TIME_W-1:0] : cap_reg;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (!sub_borrow && (n_reg < limit))
                begin
                    // One step pulse per cycle while the output is free.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        fire_next      = 1'b1;
                        num_next       = n_reg;
                        last_next      = 1'b0;
                        count_next     = '0;
                        carried_next   = '0;
                        out_total_next = '0;
                        acc_next       = sub_diff[TIME_W-1:0];
                        n_next         = n_reg + COUNT_W'(1);
                    end
                end
                else if (!sub_borrow && drop_excess_reg)
                begin
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = S_MOD;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_MOD:
            begin
                // Restoring remainder, one dividend bit per cycle, MSB first.
                rem_next     = sub_borrow ? mod_shift[TIME_W-1:0] : sub_diff[TIME_W-1:0];
                acc_next     = {acc_reg[TIME_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'(TIME_W - 1))
                begin
                    acc_next   = rem_next;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                // Closing summary item; the running total is updated here.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    fire_next      = 1'b0;
                    num_next       = '0;
                    last_next      = 1'b1;
                    count_next     = n_reg;
                    carried_next   = acc_reg;
                    out_total_next = total_sum;
                    total_next     = total_sum;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            total_reg     <= '0;
            n_reg         <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            n_reg         <= n_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        dt_reg        <= dt_next;
        cap_reg       <= cap_next;
        sum_reg       <= sum_next;
        rem_reg       <= rem_next;
        fire_reg      <= fire_next;
        num_reg       <= num_next;
        last_reg      <= last_next;
        count_reg     <= count_next;
        carried_reg   <= carried_next;
        out_total_reg <= out_total_next;
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign fire_step         = fire_reg;
    assign step_number       = num_reg;
    assign last              = last_reg;
    assign steps_this_update = count_reg;
    assign carried_time      = carried_reg;
    assign completed_total   = out_total_reg;

    // Assertions.
    `FTA_ASSERT_SAME(a_step_within_limit, state_reg == S_STEP, n_reg <= limit, "substeps exceed limit")
    `FTA_ASSERT_SAME(a_acc_within_cap, state_reg == S_STEP, acc_reg <= cap_reg, "accumulator above cap")
    `FTA_ASSERT_SAME(a_rem_below_period, state_reg == S_MOD, rem_reg < step_period_reg, "remainder not reduced")
    `FTA_ASSERT_SAME(a_pulse_not_last, out_valid_reg && fire_reg, !last_reg, "pulse item marked last")
    `FTA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state_reg != S_IDLE, "accepted item not started")

endmodule
